// File: hdl/sawbc_pkg.sv
// ----------------------------------------------------------------------------
// sawbc_pkg
// Shared geometry, operation codes, result codes and the command and status
// structures that join the cache controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sawbc_pkg;

  // Cache geometry.
  localparam int BLOCK_BITS = 6;
  localparam int SET_BITS   = 6;
  localparam int WAY_BITS   = 2;
  localparam int ADDR_BITS  = 32;

  localparam int WORD_BITS = BLOCK_BITS - 2;
  localparam int WPB       = 1 << WORD_BITS;
  localparam int NSETS     = 1 << SET_BITS;
  localparam int NWAYS     = 1 << WAY_BITS;
  localparam int LINE_BITS = SET_BITS + WAY_BITS;
  localparam int NLINES    = 1 << LINE_BITS;
  localparam int MEM_BITS  = LINE_BITS + WORD_BITS;
  localparam int NWORDS    = 1 << MEM_BITS;
  localparam int TAG_BITS  = ADDR_BITS - BLOCK_BITS - SET_BITS;
  localparam int BADDR_W   = 26;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Input operation codes.
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WDONE = 2'd1;
  localparam logic [1:0] KIND_WB    = 2'd2;
  localparam logic [1:0] KIND_REQ   = 2'd3;

  typedef struct packed {
    logic capture;  // latch a read or write access, read the tags
    logic fill_wr;  // store one refill word
    logic lookup;   // compare tags; on a miss pick and evict the victim
    logic access;   // perform the read or write on the selected line
    logic fin;      // install the refilled line
    logic wb_rd;    // read one victim word
    logic ld_wb;    // load a writeback transaction into the output register
    logic wb_next;  // advance to the next victim word
    logic ld_req;   // load the refill request into the output register
  } sawbc_cmd_t;

  typedef struct packed {
    logic hit;
    logic victim_dirty;
    logic miss_pending;
    logic fill_last;
    logic wb_last;
  } sawbc_sts_t;

endpackage

`default_nettype wire

// File: hdl/sawbc_ctrl.sv
// ----------------------------------------------------------------------------
// sawbc_ctrl
// Sequencer of the cache: accepts one transaction at a time, walks the hit,
// writeback, refill request and refill completion paths.
// ----------------------------------------------------------------------------
`default_nettype none

module sawbc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [1:0]              in_op,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire sawbc_pkg::sawbc_sts_t   sts,
  output sawbc_pkg::sawbc_cmd_t        cmd
);
  import sawbc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LOOKUP  = 9'b000000010,
    S_ACCESS  = 9'b000000100,
    S_OUT_RES = 9'b000001000,
    S_WB_RD   = 9'b000010000,
    S_WB_LOAD = 9'b000100000,
    S_OUT_WB  = 9'b001000000,
    S_OUT_REQ = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT_RES) || (state_r == S_OUT_WB) ||
                     (state_r == S_OUT_REQ);
  assign accept    = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_FILL && sts.miss_pending) begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) begin
              state_nxt = S_FIN;
            end
          end else if ((in_op == OP_READ || in_op == OP_WRITE) && !sts.miss_pending) begin
            cmd.capture = 1'b1;
            state_nxt   = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.hit) begin
          state_nxt = S_ACCESS;
        end else if (sts.victim_dirty) begin
          state_nxt = S_WB_RD;
        end else begin
          state_nxt = S_OUT_REQ;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_OUT_RES;
      end
      S_OUT_RES: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      S_WB_RD: begin
        cmd.wb_rd = 1'b1;
        state_nxt = S_WB_LOAD;
      end
      S_WB_LOAD: begin
        cmd.ld_wb = 1'b1;
        state_nxt = S_OUT_WB;
      end
      S_OUT_WB: begin
        if (!out_stall) begin
          if (sts.wb_last) begin
            cmd.ld_req = 1'b1;
            state_nxt  = S_OUT_REQ;
          end else begin
            cmd.wb_next = 1'b1;
            state_nxt   = S_WB_RD;
          end
        end
      end
      S_OUT_REQ: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_ACCESS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sawbc_dp.sv
// ----------------------------------------------------------------------------
// sawbc_dp
// Cache datapath: tag and data memories, valid and dirty bits, victim LFSR,
// pending access registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sawbc_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sawbc_pkg::sawbc_cmd_t   cmd,
  output sawbc_pkg::sawbc_sts_t        sts,
  input  wire logic [1:0]              in_op,
  input  wire logic [31:0]             in_addr,
  input  wire logic [31:0]             in_wdata,
  input  wire logic [31:0]             in_wmask,
  output logic [1:0]                   out_kind,
  output logic [31:0]                  out_rdata,
  output logic [sawbc_pkg::BADDR_W-1:0] out_block_addr,
  output logic [3:0]                   out_word_index,
  output logic                         out_was_hit,
  output logic                         out_last
);
  import sawbc_pkg::*;

  // Pending access; it is held untouched for the whole miss.
  logic                  req_write_r;
  logic [ADDR_BITS-1:0]  req_addr_r;
  logic [31:0]           req_wdata_r;
  logic [31:0]           req_wmask_r;

  logic [15:0]           lfsr_r, lfsr_nxt;
  logic [WAY_BITS-1:0]   vway_r;
  logic [NLINES-1:0]     valid_r;
  logic [NLINES-1:0]     dirty_r;
  logic [WORD_BITS-1:0]  fill_cnt_r;
  logic [WORD_BITS-1:0]  wb_cnt_r;
  logic                  mp_r;
  logic [LINE_BITS-1:0]  acc_line_r;
  logic                  acc_hit_r;
  logic [BADDR_W-1:0]    vbaddr_r;

  logic [TAG_BITS-1:0]   tag_mem [NWAYS][NSETS];
  logic [TAG_BITS-1:0]   tag_q [NWAYS];
  logic [31:0]           data_mem [NWORDS];
  logic [31:0]           data_q;

  logic [SET_BITS-1:0]   req_set, in_set;
  logic [TAG_BITS-1:0]   req_tag;
  logic [WORD_BITS-1:0]  req_word;
  logic                  hit;
  logic [WAY_BITS-1:0]   hit_way;
  logic [WAY_BITS-1:0]   new_vway;
  logic [LINE_BITS-1:0]  new_vline;
  logic [LINE_BITS-1:0]  pend_line;
  logic [MEM_BITS-1:0]   rd_addr;
  logic                  wr_en;
  logic [MEM_BITS-1:0]   wr_addr;
  logic [31:0]           wr_data;
  logic                  miss;

  assign in_set   = in_addr[BLOCK_BITS +: SET_BITS];
  assign req_set  = req_addr_r[BLOCK_BITS +: SET_BITS];
  assign req_tag  = req_addr_r[ADDR_BITS-1 -: TAG_BITS];
  assign req_word = req_addr_r[2 +: WORD_BITS];

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < NWAYS; w++) begin
      if (valid_r[{req_set, WAY_BITS'(w)}] && tag_q[w] == req_tag) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
  end

  assign lfsr_nxt  = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
  assign new_vway  = lfsr_nxt[WAY_BITS-1:0];
  assign new_vline = {req_set, new_vway};
  assign pend_line = {req_set, vway_r};
  assign miss      = cmd.lookup && !hit;

  assign sts.hit          = hit;
  assign sts.victim_dirty = valid_r[new_vline] && dirty_r[new_vline];
  assign sts.miss_pending = mp_r;
  assign sts.fill_last    = (fill_cnt_r == WORD_BITS'(WPB - 1));
  assign sts.wb_last      = (wb_cnt_r == WORD_BITS'(WPB - 1));

  always_comb begin
    priority if (cmd.wb_rd) begin
      rd_addr = {pend_line, wb_cnt_r};
    end else if (cmd.fin) begin
      rd_addr = {pend_line, req_word};
    end else begin
      rd_addr = {req_set, hit_way, req_word};
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {acc_line_r, req_word};
    wr_data = (data_q & ~req_wmask_r) | (req_wdata_r & req_wmask_r);
    if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = {pend_line, fill_cnt_r};
      wr_data = in_wdata;
    end else if (cmd.access && req_write_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_mem[wr_addr] <= wr_data;
    end
    data_q <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NWAYS; w++) begin
      if (cmd.fin && vway_r == WAY_BITS'(w)) begin
        tag_mem[w][req_set] <= req_tag;
      end
      if (cmd.capture) begin
        tag_q[w] <= tag_mem[w][in_set];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r     <= LFSR_SEED;
      vway_r     <= '0;
      valid_r    <= '0;
      dirty_r    <= '0;
      fill_cnt_r <= '0;
      wb_cnt_r   <= '0;
      mp_r       <= 1'b0;
    end else begin
      if (miss) begin
        lfsr_r             <= lfsr_nxt;
        vway_r             <= new_vway;
        valid_r[new_vline] <= 1'b0;
        dirty_r[new_vline] <= 1'b0;
        fill_cnt_r         <= '0;
        wb_cnt_r           <= '0;
        mp_r               <= 1'b1;
      end
      if (cmd.fill_wr) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
      if (cmd.wb_next) begin
        wb_cnt_r <= wb_cnt_r + 1'b1;
      end
      if (cmd.fin) begin
        valid_r[pend_line] <= 1'b1;
        dirty_r[pend_line] <= 1'b0;
        mp_r               <= 1'b0;
      end
      if (cmd.access && req_write_r) begin
        dirty_r[acc_line_r] <= 1'b1;
      end
    end
  end

  // Access payload and output register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_write_r <= (in_op == OP_WRITE);
      req_addr_r  <= ADDR_BITS'(in_addr);
      req_wdata_r <= in_wdata;
      req_wmask_r <= in_wmask;
    end
    if (cmd.lookup) begin
      acc_line_r <= {req_set, hit_way};
      acc_hit_r  <= 1'b1;
      vbaddr_r   <= BADDR_W'({tag_q[new_vway], req_set});
    end
    if (cmd.fin) begin
      acc_line_r <= pend_line;
      acc_hit_r  <= 1'b0;
    end
    priority if (cmd.access) begin
      out_kind       <= req_write_r ? KIND_WDONE : KIND_READ;
      out_rdata      <= req_write_r ? 32'd0 : data_q;
      out_block_addr <= '0;
      out_word_index <= '0;
      out_was_hit    <= acc_hit_r;
      out_last       <= 1'b1;
    end else if (cmd.ld_wb) begin
      out_kind       <= KIND_WB;
      out_rdata      <= data_q;
      out_block_addr <= vbaddr_r;
      out_word_index <= 4'(wb_cnt_r);
      out_was_hit    <= 1'b0;
      out_last       <= 1'b0;
    end else if (miss || cmd.ld_req) begin
      out_kind       <= KIND_REQ;
      out_rdata      <= '0;
      out_block_addr <= BADDR_W'(req_addr_r >> BLOCK_BITS);
      out_word_index <= '0;
      out_was_hit    <= 1'b0;
      out_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/set_assoc_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_unit
// Set-associative write-back, write-allocate data cache with LFSR victim
// selection, built as a sequencer and a datapath.
// ----------------------------------------------------------------------------
// Sequence: a hit goes through lookup and access before its result is
//   offered; a clean miss goes from lookup to its refill request, and a
//   dirty miss first reads and offers each writeback word (16 words) first.
// Flow: the one-transaction-at-a-time sequencer takes no new access until
//   the previous result is taken; refill words are written as accepted, and
//   the last one installs the line and performs the deferred access.
// Reset: synchronous active-low rst_n clears valid and dirty bits, the LFSR
//   (to 0xACE1), the miss state and the sequencer; tags and data are not reset.
`default_nettype none

module set_assoc_writeback_cache_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_op,
  input  wire logic [31:0]                  in_addr,
  input  wire logic [31:0]                  in_wdata,
  input  wire logic [31:0]                  in_wmask,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_kind,
  output logic [31:0]                       out_rdata,
  output logic [sawbc_pkg::BADDR_W-1:0]     out_block_addr,
  output logic [3:0]                        out_word_index,
  output logic                              out_was_hit,
  output logic                              out_last
);
  import sawbc_pkg::*;

  // The sequencer owns all handshakes; the datapath only follows commands.
  sawbc_cmd_t cmd;
  sawbc_sts_t sts;

  sawbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Refill words are written straight into the data memory in the cycle the
  // transaction is accepted; the last one triggers line installation and the
  // deferred access, which then reports was_hit low.
  sawbc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_addr        (in_addr),
    .in_wdata       (in_wdata),
    .in_wmask       (in_wmask),
    .out_kind       (out_kind),
    .out_rdata      (out_rdata),
    .out_block_addr (out_block_addr),
    .out_word_index (out_word_index),
    .out_was_hit    (out_was_hit),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// File: hdl/sawbc_checker.sv
// ----------------------------------------------------------------------------
// sawbc_checker
// Port-level checks of the cache's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sawbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [31:0] out_rdata,
  input wire logic        out_was_hit,
  input wire logic        out_last
);
  import sawbc_pkg::*;

  // A held result must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_rdata))
    else $error("result changed while stalled");

  // Only one transaction is in flight, so no input is taken while a result waits.
  a_serial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // A refill request always closes the results of its transaction.
  a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQ |-> out_last && !out_was_hit)
    else $error("refill request without last");

  // Writeback words are never final and never flagged as hits.
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WB |-> !out_last && !out_was_hit)
    else $error("bad writeback transaction");

endmodule

bind set_assoc_writeback_cache_unit sawbc_checker u_sawbc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kind    (out_kind),
  .out_rdata   (out_rdata),
  .out_was_hit (out_was_hit),
  .out_last    (out_last)
);

`default_nettype wire
